/* hdl/lrupr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lrupr_pkg;

  // widest frame index (for FRAMES up to 64) and stored page that any parameter setting can produce
  localparam int IDX_MAX_W  = 6;
  localparam int PAGE_MAX_W = 16;

  localparam int PAGE_IN_W  = 16;
  localparam int SLOT_W     = 4;
  localparam int STAMP_W    = 32;
  localparam int FAULT_W    = 32;
  localparam int FCOUNT_W   = 5;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // register index taken from paddr[2]
  localparam logic REG_FRAME_COUNT = 1'b0;

  localparam logic [FCOUNT_W-1:0] FCOUNT_RESET = 5'd16;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_UPDATE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic                  hit;
    logic [IDX_MAX_W-1:0]  hit_idx;
    logic                  empty;
    logic [IDX_MAX_W-1:0]  empty_idx;
    logic [IDX_MAX_W-1:0]  min_idx;
    logic [PAGE_MAX_W-1:0] min_page;
  } scan_res_t;

endpackage

`default_nettype wire

/* hdl/lrupr_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface lrupr_req_if;
  logic        valid;
  logic        ready;
  logic [15:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface

interface lrupr_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [3:0]  slot;
  logic        evicted_valid;
  logic [15:0] evicted_page;
  logic [31:0] fault_total;

  modport source (
    output valid, output hit, output slot, output evicted_valid,
    output evicted_page, output fault_total, input ready
  );
  modport sink (
    input valid, input hit, input slot, input evicted_valid,
    input evicted_page, input fault_total, output ready
  );
endinterface

`default_nettype wire

/* hdl/lrupr_frame_mem.sv */
`timescale 1ns / 1ps
`default_nettype none

module lrupr_frame_mem import lrupr_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4,
  parameter int PW    = 16
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [IDX_W-1:0]   wr_idx_i,
  input  logic [PW-1:0]      wr_page_i,
  input  logic [STAMP_W-1:0] wr_stamp_i,
  input  logic               re_i,
  input  logic [IDX_W-1:0]   rd_idx_i,
  output logic [PW-1:0]      rd_page_o,
  output logic [STAMP_W-1:0] rd_stamp_o
);

  logic [PW-1:0]      page_mem  [DEPTH];
  logic [STAMP_W-1:0] stamp_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      page_mem[wr_idx_i]  <= wr_page_i;
      stamp_mem[wr_idx_i] <= wr_stamp_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rd_page_o  <= page_mem[rd_idx_i];
      rd_stamp_o <= stamp_mem[rd_idx_i];
    end
  end

endmodule

`default_nettype wire

/* hdl/lrupr_scan.sv */
`timescale 1ns / 1ps
`default_nettype none

module lrupr_scan import lrupr_pkg::*; #(
  parameter int IDX_W = 4,
  parameter int PW    = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               clr_i,
  input  logic               ent_vld_i,
  input  logic               ent_valid_i,
  input  logic [PW-1:0]      ent_page_i,
  input  logic [STAMP_W-1:0] ent_stamp_i,
  input  logic [IDX_W-1:0]   ent_idx_i,
  input  logic [PW-1:0]      key_i,
  output scan_res_t          res_o
);

  logic               hit_q, hit_d;
  logic [IDX_W-1:0]   hit_idx_q, hit_idx_d;
  logic               empty_q, empty_d;
  logic [IDX_W-1:0]   empty_idx_q, empty_idx_d;
  logic               min_vld_q, min_vld_d;
  logic [IDX_W-1:0]   min_idx_q, min_idx_d;
  logic [STAMP_W-1:0] min_stamp_q, min_stamp_d;
  logic [PW-1:0]      min_page_q, min_page_d;
  logic               page_eq;
  logic               stamp_lt;

  assign page_eq  = ent_page_i == key_i;
  assign stamp_lt = ent_stamp_i < min_stamp_q;

  always_comb begin
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    empty_d     = empty_q;
    empty_idx_d = empty_idx_q;
    min_vld_d   = min_vld_q;
    min_idx_d   = min_idx_q;
    min_stamp_d = min_stamp_q;
    min_page_d  = min_page_q;
    if (clr_i) begin
      hit_d     = 1'b0;
      empty_d   = 1'b0;
      min_vld_d = 1'b0;
    end else if (ent_vld_i) begin
      // first match and first hole win, ties on stamp keep the lower index
      if (ent_valid_i && page_eq && !hit_q) begin
        hit_d     = 1'b1;
        hit_idx_d = ent_idx_i;
      end
      if (!ent_valid_i && !empty_q) begin
        empty_d     = 1'b1;
        empty_idx_d = ent_idx_i;
      end
      if (ent_valid_i && (!min_vld_q || stamp_lt)) begin
        min_vld_d   = 1'b1;
        min_idx_d   = ent_idx_i;
        min_stamp_d = ent_stamp_i;
        min_page_d  = ent_page_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q     <= 1'b0;
      empty_q   <= 1'b0;
      min_vld_q <= 1'b0;
    end else begin
      hit_q     <= hit_d;
      empty_q   <= empty_d;
      min_vld_q <= min_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q   <= hit_idx_d;
    empty_idx_q <= empty_idx_d;
    min_idx_q   <= min_idx_d;
    min_stamp_q <= min_stamp_d;
    min_page_q  <= min_page_d;
  end

  always_comb begin
    res_o.hit       = hit_q;
    res_o.hit_idx   = IDX_MAX_W'(hit_idx_q);
    res_o.empty     = empty_q;
    res_o.empty_idx = IDX_MAX_W'(empty_idx_q);
    res_o.min_idx   = IDX_MAX_W'(min_idx_q);
    res_o.min_page  = PAGE_MAX_W'(min_page_q);
  end

endmodule

`default_nettype wire

/* hdl/lru_page_replacement.sv */
`timescale 1ns / 1ps
`default_nettype none

// LRU page replacement with per-frame use stamps. Each request item carries one
// page number; the block searches the first frame_count frames (0 reads as 1,
// values above FRAMES read as FRAMES) and returns one response item with hit,
// the frame used, the evicted page if a resident page was replaced, and the
// saturating fault count. A single compare unit visits one frame per cycle
// through the frame memory's read port. After acceptance an item passes through
// the scan reads, a drain of the last read, the frame update and the load of the
// output register, which waits while the output still holds an unaccepted
// response; the next request is taken only after the previous result has been
// moved into the output register. Stamps come from a wrapping 32-bit counter
// and are compared as unsigned values. The frame_count register sits at APB
// byte address 0; the user must write it only while the block is idle, as the
// block itself does not enforce this.
module lru_page_replacement import lrupr_pkg::*; #(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  lrupr_req_if.sink             req_if,
  lrupr_rsp_if.source           rsp_if
);

  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W = $clog2(FRAMES + 1);
  localparam int NW    = (CNT_W > FCOUNT_W) ? CNT_W : FCOUNT_W;
  localparam int PW    = (PAGE_BITS < PAGE_IN_W) ? PAGE_BITS : PAGE_IN_W;

  state_e state_q, state_d;

  logic [FCOUNT_W-1:0] fc_q;
  logic [NW-1:0]       fc_ext;
  logic [CNT_W-1:0]    n_act;
  logic                last_issue;

  logic [PW-1:0]      page_q;
  logic [CNT_W-1:0]   rd_idx_q;
  logic               ent_vld_q;
  logic [IDX_W-1:0]   ent_idx_q;
  logic [FRAMES-1:0]  valid_q;
  logic [STAMP_W-1:0] use_q;
  logic [FAULT_W-1:0] fault_q;
  logic [STAMP_W-1:0] use_next;

  logic accept;
  logic rd_en;
  logic scan_clr;
  logic mem_we;
  logic load_out;
  logic cfg_wr;

  logic [PW-1:0]      rd_page;
  logic [STAMP_W-1:0] rd_stamp;
  scan_res_t          scan_res;

  logic [IDX_W-1:0] slot_sel;
  logic             evict;

  logic                  res_hit_q;
  logic [IDX_W-1:0]      res_slot_q;
  logic                  res_evict_q;
  logic [PAGE_MAX_W-1:0] res_page_q;

  logic                  out_vld_q;
  logic                  out_hit_q;
  logic [SLOT_W-1:0]     out_slot_q;
  logic                  out_evict_q;
  logic [PAGE_IN_W-1:0]  out_page_q;
  logic [FAULT_W-1:0]    out_fault_q;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_FRAME_COUNT) ? APB_DATA_W'(fc_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q <= FCOUNT_RESET;
    end else if (cfg_wr && paddr[2] == REG_FRAME_COUNT) begin
      fc_q <= pwdata[FCOUNT_W-1:0];
    end
  end

  // clamp the frame count into 1..FRAMES
  assign fc_ext = NW'(fc_q);
  always_comb begin
    if (fc_q == '0) begin
      n_act = CNT_W'(1);
    end else if (fc_ext > NW'(FRAMES)) begin
      n_act = CNT_W'(FRAMES);
    end else begin
      n_act = fc_ext[CNT_W-1:0];
    end
  end

  assign last_issue = rd_idx_q == (n_act - CNT_W'(1));
  assign accept     = req_if.valid && req_if.ready;

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (last_issue) state_d = S_DRAIN;
      end
      S_DRAIN:  state_d = S_UPDATE;
      S_UPDATE: state_d = S_DONE;
      S_DONE: begin
        if (!out_vld_q || rsp_if.ready) state_d = S_IDLE;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    req_if.ready = 1'b0;
    rd_en        = 1'b0;
    mem_we       = 1'b0;
    load_out     = 1'b0;
    case (state_q)
      S_IDLE:   req_if.ready = 1'b1;
      S_SCAN:   rd_en = 1'b1;
      S_DRAIN:  ;
      S_UPDATE: mem_we = 1'b1;
      S_DONE:   load_out = !out_vld_q || rsp_if.ready;
      default:  ;
    endcase
  end

  assign scan_clr = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // scan address and entry tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q  <= '0;
      ent_vld_q <= 1'b0;
    end else begin
      ent_vld_q <= rd_en;
      if (accept) begin
        rd_idx_q <= '0;
      end else if (rd_en) begin
        rd_idx_q <= rd_idx_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ent_idx_q <= rd_idx_q[IDX_W-1:0];
    if (accept) begin
      page_q <= req_if.page_number[PW-1:0];
    end
  end

  lrupr_frame_mem #(
    .DEPTH (FRAMES),
    .IDX_W (IDX_W),
    .PW    (PW)
  ) u_mem (
    .clk_i      (clk_i),
    .we_i       (mem_we),
    .wr_idx_i   (slot_sel),
    .wr_page_i  (page_q),
    .wr_stamp_i (use_next),
    .re_i       (rd_en),
    .rd_idx_i   (rd_idx_q[IDX_W-1:0]),
    .rd_page_o  (rd_page),
    .rd_stamp_o (rd_stamp)
  );

  lrupr_scan #(
    .IDX_W (IDX_W),
    .PW    (PW)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clr_i       (scan_clr),
    .ent_vld_i   (ent_vld_q),
    .ent_valid_i (valid_q[ent_idx_q]),
    .ent_page_i  (rd_page),
    .ent_stamp_i (rd_stamp),
    .ent_idx_i   (ent_idx_q),
    .key_i       (page_q),
    .res_o       (scan_res)
  );

  // pick the frame to touch: hit, else first hole, else oldest stamp
  always_comb begin
    evict = 1'b0;
    if (scan_res.hit) begin
      slot_sel = scan_res.hit_idx[IDX_W-1:0];
    end else if (scan_res.empty) begin
      slot_sel = scan_res.empty_idx[IDX_W-1:0];
    end else begin
      slot_sel = scan_res.min_idx[IDX_W-1:0];
      evict    = 1'b1;
    end
  end

  assign use_next = use_q + STAMP_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      use_q   <= '0;
      fault_q <= '0;
    end else if (mem_we) begin
      valid_q[slot_sel] <= 1'b1;
      use_q             <= use_next;
      if (!scan_res.hit && fault_q != '1) begin
        fault_q <= fault_q + FAULT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      res_hit_q   <= scan_res.hit;
      res_slot_q  <= slot_sel;
      res_evict_q <= evict;
      res_page_q  <= evict ? scan_res.min_page : '0;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load_out) begin
      out_vld_q <= 1'b1;
    end else if (rsp_if.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_hit_q   <= res_hit_q;
      out_slot_q  <= SLOT_W'(res_slot_q);
      out_evict_q <= res_evict_q;
      out_page_q  <= PAGE_IN_W'(res_page_q);
      out_fault_q <= fault_q;
    end
  end

  assign rsp_if.valid         = out_vld_q;
  assign rsp_if.hit           = out_hit_q;
  assign rsp_if.slot          = out_slot_q;
  assign rsp_if.evicted_valid = out_evict_q;
  assign rsp_if.evicted_page  = out_page_q;
  assign rsp_if.fault_total   = out_fault_q;

  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    accept |=> !req_if.ready
  ) else $error("request taken while an item is in flight");

  a_hit_no_evict: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    rsp_if.valid && rsp_if.hit |-> !rsp_if.evicted_valid && rsp_if.evicted_page == '0
  ) else $error("hit reported together with an eviction");

  a_fault_monotonic: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> fault_q >= $past(fault_q)
  ) else $error("fault count went backwards");

  a_update_after_drain: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> $past(state_q) == S_DRAIN && !ent_vld_q
  ) else $error("frame update before the scan finished");

endmodule

`default_nettype wire
